@@ rtl/prd_pkg.sv @@
package prd_pkg;

    localparam int unsigned QueueDepth = 4;

    localparam logic [7:0]  DefFlag   = 8'd17;
    localparam logic [7:0]  GroupFlag = 8'd61;
    localparam logic [31:0] HeadBytes = 32'd9;

    localparam logic [1:0] KIND_HEADER   = 2'd0;
    localparam logic [1:0] KIND_DOC      = 2'd1;
    localparam logic [1:0] KIND_COMPLETE = 2'd2;
    localparam logic [1:0] KIND_ERROR    = 2'd3;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_DEF_FLAG  = 3'd1;
    localparam logic [2:0] ERR_TERM      = 3'd2;
    localparam logic [2:0] ERR_LENGTH    = 3'd3;
    localparam logic [2:0] ERR_GROUP     = 3'd4;
    localparam logic [2:0] ERR_TRUNCATED = 3'd5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] category;
        logic [31:0] term_frequency;
        logic [31:0] doc_count;
        logic [31:0] doc_id;
        logic [31:0] doc_frequency;
        logic [2:0]  error_code;
        logic        last;
    } t_result;

    // Work handed from the byte front to the result back.
    typedef struct packed {
        logic    has_a;
        logic    has_b;
        t_result res_a;
        t_result res_b;
    } t_work;

endpackage

@@ rtl/prd_front.sv @@
module prd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_byte_order,
    input  logic          i_take,
    input  logic          i_first_byte,
    input  logic [7:0]    i_data_byte,
    input  logic [31:0]   i_entry_length,
    input  logic [31:0]   i_expected_ident,
    output prd_pkg::t_work o_work
);
    import prd_pkg::*;

    localparam logic [3:0] P_IDLE  = 4'd0;
    localparam logic [3:0] P_FLAG  = 4'd1;
    localparam logic [3:0] P_IDENT = 4'd2;
    localparam logic [3:0] P_DLEN  = 4'd3;
    localparam logic [3:0] P_GFLAG = 4'd4;
    localparam logic [3:0] P_CAT   = 4'd5;
    localparam logic [3:0] P_TFREQ = 4'd6;
    localparam logic [3:0] P_NDOCS = 4'd7;
    localparam logic [3:0] P_DID   = 4'd8;
    localparam logic [3:0] P_DFREQ = 4'd9;
    localparam logic [3:0] P_DONE  = 4'd10;

    logic [3:0]  r_phase, n_phase;
    logic [1:0]  r_biw, n_biw;
    logic [31:0] r_word, n_word;
    logic [31:0] r_seen, n_seen;
    logic [31:0] r_len, n_len;
    logic [31:0] r_term, n_term;
    logic [31:0] r_cat, n_cat;
    logic [31:0] r_tf, n_tf;
    logic [31:0] r_left, n_left;
    logic [31:0] r_did, n_did;
    t_work       n_work;
    logic [31:0] w_word;
    logic        stop;

    function automatic t_result mk(input logic [1:0] k, input logic [31:0] c,
                                   input logic [31:0] t, input logic [31:0] d,
                                   input logic [31:0] id, input logic [31:0] df,
                                   input logic [2:0] e, input logic l);
        t_result r;
        r.kind = k; r.category = c; r.term_frequency = t; r.doc_count = d;
        r.doc_id = id; r.doc_frequency = df; r.error_code = e; r.last = l;
        return r;
    endfunction

    // Byte decode: one step of the record parser per accepted item.
    always_comb begin
        n_phase = r_phase; n_biw = r_biw; n_word = r_word; n_seen = r_seen;
        n_len = r_len; n_term = r_term; n_cat = r_cat; n_tf = r_tf;
        n_left = r_left; n_did = r_did;
        n_work = '0;
        stop = 1'b0;
        w_word = '0;
        if (i_take) begin
            if (i_first_byte) begin
                n_phase = P_FLAG; n_biw = '0; n_word = '0; n_seen = '0;
                n_len = i_entry_length; n_term = i_expected_ident;
                n_cat = '0; n_tf = '0; n_left = '0; n_did = '0;
                if (i_entry_length == '0) begin
                    n_work.has_a = 1'b1;
                    n_work.res_a = mk(KIND_ERROR, '0, '0, '0, '0, '0,
                                      ERR_TRUNCATED, 1'b1);
                    n_phase = P_DONE;
                    stop = 1'b1;
                end
            end else if (r_phase == P_IDLE || r_phase == P_DONE) begin
                stop = 1'b1;
            end
            if (!stop) begin
                n_seen = n_seen + 32'd1;
                if (n_phase == P_FLAG) begin
                    if (i_data_byte != DefFlag) begin
                        n_work.has_a = 1'b1;
                        n_work.res_a = mk(KIND_ERROR, '0, '0, '0, '0, '0,
                                          ERR_DEF_FLAG, 1'b1);
                        n_phase = P_DONE; stop = 1'b1;
                    end else begin
                        n_phase = P_IDENT;
                    end
                end else if (n_phase == P_GFLAG) begin
                    if (i_data_byte != GroupFlag) begin
                        n_work.has_a = 1'b1;
                        n_work.res_a = mk(KIND_ERROR, '0, '0, '0, '0, '0,
                                          ERR_GROUP, 1'b1);
                        n_phase = P_DONE; stop = 1'b1;
                    end else begin
                        n_phase = P_CAT;
                    end
                end else begin
                    if (i_byte_order) w_word = {n_word[23:0], i_data_byte};
                    else w_word = n_word | ({24'd0, i_data_byte} << {n_biw, 3'b000});
                    n_word = w_word;
                    if (n_biw != 2'd3) begin
                        n_biw = n_biw + 2'd1;
                    end else begin
                        n_biw = '0; n_word = '0;
                        case (n_phase)
                            P_IDENT: begin
                                if (w_word != n_term) begin
                                    n_work.has_a = 1'b1;
                                    n_work.res_a = mk(KIND_ERROR, '0, '0, '0, '0, '0,
                                                      ERR_TERM, 1'b1);
                                    n_phase = P_DONE; stop = 1'b1;
                                end else n_phase = P_DLEN;
                            end
                            P_DLEN: begin
                                if (w_word + HeadBytes != n_len) begin
                                    n_work.has_a = 1'b1;
                                    n_work.res_a = mk(KIND_ERROR, '0, '0, '0, '0, '0,
                                                      ERR_LENGTH, 1'b1);
                                    n_phase = P_DONE; stop = 1'b1;
                                end else n_phase = P_GFLAG;
                            end
                            P_CAT: begin n_cat = w_word; n_phase = P_TFREQ; end
                            P_TFREQ: begin n_tf = w_word; n_phase = P_NDOCS; end
                            P_NDOCS: begin
                                n_left = w_word;
                                n_work.has_a = 1'b1;
                                n_work.res_a = mk(KIND_HEADER, n_cat, n_tf, w_word,
                                                  '0, '0, ERR_NONE, 1'b0);
                                n_phase = (w_word != '0) ? P_DID : P_GFLAG;
                            end
                            P_DID: begin n_did = w_word; n_phase = P_DFREQ; end
                            default: begin
                                n_work.has_a = 1'b1;
                                n_work.res_a = mk(KIND_DOC, n_cat, n_tf, '0,
                                                  n_did, w_word, ERR_NONE, 1'b0);
                                n_left = n_left - 32'd1;
                                n_phase = (n_left != '0) ? P_DID : P_GFLAG;
                            end
                        endcase
                    end
                end
                // End of record check after the byte.
                if (!stop && n_seen == n_len) begin
                    n_work.has_b = 1'b1;
                    if (n_phase == P_GFLAG && n_biw == '0)
                        n_work.res_b = mk(KIND_COMPLETE, '0, '0, '0, '0, '0,
                                          ERR_NONE, 1'b1);
                    else
                        n_work.res_b = mk(KIND_ERROR, '0, '0, '0, '0, '0,
                                          ERR_TRUNCATED, 1'b1);
                    n_phase = P_DONE;
                end
            end
        end
    end

    assign o_work = n_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE; r_biw <= '0; r_word <= '0; r_seen <= '0;
            r_len <= '0; r_term <= '0; r_cat <= '0; r_tf <= '0;
            r_left <= '0; r_did <= '0;
        end else begin
            r_phase <= n_phase; r_biw <= n_biw; r_word <= n_word; r_seen <= n_seen;
            r_len <= n_len; r_term <= n_term; r_cat <= n_cat; r_tf <= n_tf;
            r_left <= n_left; r_did <= n_did;
        end
    end

endmodule

@@ rtl/prd_queue.sv @@
module prd_queue #(
    parameter int unsigned Depth = prd_pkg::QueueDepth
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  prd_pkg::t_work    i_work,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output prd_pkg::t_result  o_head
);
    import prd_pkg::*;

    localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

    t_result        r_mem [Depth];
    logic [Aw-1:0]  r_rd, r_wr;
    logic [Aw:0]    r_cnt;
    logic [Aw-1:0]  wr2;
    logic           do_pop;
    logic [1:0]     n_push;

    function automatic logic [Aw-1:0] inc(input logic [Aw-1:0] p);
        return (p == Aw'(Depth - 1)) ? '0 : p + Aw'(1);
    endfunction

    assign do_pop  = i_pop && !o_empty;
    assign wr2     = inc(r_wr);
    assign n_push  = {1'b0, i_work.has_a} + {1'b0, i_work.has_b};
    assign o_empty = (r_cnt == '0);
    // Room for two results is needed before the next item may enter.
    assign o_full  = (r_cnt > (Aw+1)'(Depth - 2));
    assign o_head  = r_mem[r_rd];

    // Result storage: up to two writes per item.
    always_ff @(posedge i_clk) begin
        if (i_work.has_a) r_mem[r_wr] <= i_work.res_a;
        if (i_work.has_b) begin
            if (i_work.has_a) r_mem[wr2] <= i_work.res_b;
            else r_mem[r_wr] <= i_work.res_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0; r_wr <= '0; r_cnt <= '0;
        end else begin
            if (n_push == 2'd1) r_wr <= wr2;
            else if (n_push == 2'd2) r_wr <= inc(wr2);
            if (do_pop) r_rd <= inc(r_rd);
            r_cnt <= r_cnt + (Aw+1)'(n_push) - (Aw+1)'(do_pop);
        end
    end

endmodule

@@ rtl/posting_record_decoder.sv @@
// Posting record decoder: push one record byte per cycle (first_byte marks
// the start, with entry_length and expected_ident). An item is taken every
// cycle while full is low; each byte is parsed and its up to
// two results go into a four-entry result queue read through empty and pop.
// Full rises while fewer than two queue slots remain free. byte_order is
// written through the cfg channel, which is always ready.
module posting_record_decoder #(
    parameter int unsigned QDepth = prd_pkg::QueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_first_byte,
    input  logic [7:0]  i_data_byte,
    input  logic [31:0] i_entry_length,
    input  logic [31:0] i_expected_ident,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_result_kind,
    output logic [31:0] o_category,
    output logic [31:0] o_term_frequency,
    output logic [31:0] o_doc_count,
    output logic [31:0] o_doc_id,
    output logic [31:0] o_doc_frequency,
    output logic [2:0]  o_error_code,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_byte_order
);
    import prd_pkg::*;

    logic    r_order;
    t_work   work;
    t_result head;

    assign o_cfg_ready = 1'b1;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_order <= 1'b0;
        else if (i_cfg_valid) r_order <= i_cfg_byte_order;
    end

    prd_front u_front (
        .i_clk, .i_rst_n, .i_byte_order(r_order), .i_take(push && !full),
        .i_first_byte, .i_data_byte, .i_entry_length, .i_expected_ident,
        .o_work(work)
    );

    prd_queue #(.Depth(QDepth)) u_queue (
        .i_clk, .i_rst_n, .i_work(work), .i_pop(pop), .o_full(full),
        .o_empty(empty), .o_head(head)
    );

    assign o_result_kind    = head.kind;
    assign o_category       = head.category;
    assign o_term_frequency = head.term_frequency;
    assign o_doc_count      = head.doc_count;
    assign o_doc_id         = head.doc_id;
    assign o_doc_frequency  = head.doc_frequency;
    assign o_error_code     = head.error_code;
    assign o_last           = head.last;

endmodule

@@ rtl/prd_checker.sv @@
module prd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [1:0] o_result_kind,
    input logic [2:0] o_error_code,
    input logic       o_last
);
    import prd_pkg::*;

    // Complete and error results always close the record.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_result_kind == KIND_ERROR || o_result_kind == KIND_COMPLETE)
        |-> o_last) else $error("closing result without last");

    // Only error results carry an error code.
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result_kind != KIND_ERROR |-> o_error_code == ERR_NONE)
        else $error("error code outside error result");

    // A full queue is never empty.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !empty) else $error("full while empty");

    // A waiting result stays until popped.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty) else $error("result dropped");

endmodule

bind posting_record_decoder prd_checker u_chk (
    .i_clk, .i_rst_n, .full, .empty, .pop, .o_result_kind, .o_error_code, .o_last
);

@@ verif/posting_record_checker.sv @@
// Watches the byte input and the result queue of the decoder, predicts each result
// from the accepted bytes and compares it with what the block hands out.
module posting_record_checker
    import prd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic        full,
    input  logic        i_first_byte,
    input  logic [7:0]  i_data_byte,
    input  logic [31:0] i_entry_length,
    input  logic [31:0] i_expected_ident,
    input  logic        empty,
    input  logic        pop,
    input  logic [1:0]  o_result_kind,
    input  logic [31:0] o_category,
    input  logic [31:0] o_term_frequency,
    input  logic [31:0] o_doc_count,
    input  logic [31:0] o_doc_id,
    input  logic [31:0] o_doc_frequency,
    input  logic [2:0]  o_error_code,
    input  logic        o_last,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic        i_cfg_byte_order,
    output int          o_errors,
    output int          o_pending,
    output int          o_results_seen,
    output int          o_records_done
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_FLAG, PH_IDENT, PH_DLEN, PH_GFLAG, PH_CAT, PH_TFREQ,
        PH_NDOCS, PH_DID, PH_DFREQ, PH_DONE
    } t_phase;

    t_phase      phase;
    logic        order_big;
    logic [1:0]  byte_in_word;
    logic [31:0] word_acc;
    logic [31:0] bytes_seen;
    logic [31:0] record_length;
    logic [31:0] wanted_term;
    logic [31:0] group_category;
    logic [31:0] group_term_freq;
    logic [31:0] docs_left;
    logic [31:0] doc_id_held;

    t_result expected_results[$];

    function automatic t_result make_result(logic [1:0] kind, logic [31:0] cat,
                                            logic [31:0] tf, logic [31:0] dc,
                                            logic [31:0] id, logic [31:0] df,
                                            logic [2:0] err, logic last);
        t_result r;
        r.kind = kind;
        r.category = cat;
        r.term_frequency = tf;
        r.doc_count = dc;
        r.doc_id = id;
        r.doc_frequency = df;
        r.error_code = err;
        r.last = last;
        return r;
    endfunction

    // Add one prediction at the tail of the expected list.
    task automatic queue_result(t_result r);
        expected_results.insert(expected_results.size(), r);
    endtask

    // Record an error result and close the record.
    task automatic reject_record(logic [2:0] code);
        queue_result(make_result(KIND_ERROR, '0, '0, '0, '0, '0, code, 1'b1));
        phase = PH_DONE;
    endtask

    // Advance the decoder state by one accepted byte.
    task automatic decode_byte(logic first, logic [7:0] b, logic [31:0] len,
                               logic [31:0] ident);
        logic [31:0] w;
        if (first) begin
            phase = PH_FLAG;
            byte_in_word = 0;
            word_acc = 0;
            bytes_seen = 0;
            record_length = len;
            wanted_term = ident;
            group_category = 0;
            group_term_freq = 0;
            docs_left = 0;
            doc_id_held = 0;
            if (len == 0) begin
                reject_record(ERR_TRUNCATED);
                return;
            end
        end else if (phase == PH_IDLE || phase == PH_DONE) begin
            return;
        end
        bytes_seen++;
        if (phase == PH_FLAG) begin
            if (b != DefFlag) begin
                reject_record(ERR_DEF_FLAG);
                return;
            end
            phase = PH_IDENT;
        end else if (phase == PH_GFLAG) begin
            if (b != GroupFlag) begin
                reject_record(ERR_GROUP);
                return;
            end
            phase = PH_CAT;
        end else begin
            if (order_big) word_acc = {word_acc[23:0], b};
            else word_acc = word_acc | (32'(b) << (8 * byte_in_word));
            if (byte_in_word != 2'd3) begin
                byte_in_word++;
            end else begin
                w = word_acc;
                byte_in_word = 0;
                word_acc = 0;
                case (phase)
                    PH_IDENT: begin
                        if (w != wanted_term) begin
                            reject_record(ERR_TERM);
                            return;
                        end
                        phase = PH_DLEN;
                    end
                    PH_DLEN: begin
                        if (w + HeadBytes != record_length) begin
                            reject_record(ERR_LENGTH);
                            return;
                        end
                        phase = PH_GFLAG;
                    end
                    PH_CAT: begin
                        group_category = w;
                        phase = PH_TFREQ;
                    end
                    PH_TFREQ: begin
                        group_term_freq = w;
                        phase = PH_NDOCS;
                    end
                    PH_NDOCS: begin
                        docs_left = w;
                        queue_result(make_result(KIND_HEADER,
                            group_category, group_term_freq, w, '0, '0,
                            ERR_NONE, 1'b0));
                        phase = (w != 0) ? PH_DID : PH_GFLAG;
                    end
                    PH_DID: begin
                        doc_id_held = w;
                        phase = PH_DFREQ;
                    end
                    default: begin
                        queue_result(make_result(KIND_DOC,
                            group_category, group_term_freq, '0, doc_id_held, w,
                            ERR_NONE, 1'b0));
                        docs_left--;
                        phase = (docs_left != 0) ? PH_DID : PH_GFLAG;
                    end
                endcase
            end
        end
        if (bytes_seen == record_length) begin
            if (phase == PH_GFLAG && byte_in_word == 0) begin
                queue_result(make_result(KIND_COMPLETE, '0, '0, '0, '0, '0,
                                         ERR_NONE, 1'b1));
                phase = PH_DONE;
            end else begin
                reject_record(ERR_TRUNCATED);
            end
        end
    endtask

    // Compare one handed-out result with the oldest prediction.
    task automatic compare_result(t_result got);
        t_result want;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result %p", $time, got);
            o_errors++;
            return;
        end
        want = expected_results.pop_front();
        if (got !== want) begin
            $display("%0t: result mismatch: expected %p, actual %p", $time,
                     want, got);
            o_errors++;
        end
        if (got.last) o_records_done++;
    endtask

    // A byte taken at the same edge as a configuration write still uses the
    // old byte order.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase = PH_IDLE;
            order_big = 1'b0;
            byte_in_word = 0;
            word_acc = 0;
            bytes_seen = 0;
            record_length = 0;
            wanted_term = 0;
            group_category = 0;
            group_term_freq = 0;
            docs_left = 0;
            doc_id_held = 0;
            expected_results.delete();
            o_errors = 0;
            o_results_seen = 0;
            o_records_done = 0;
        end else begin
            if (!empty && pop) begin
                compare_result(make_result(o_result_kind, o_category,
                    o_term_frequency, o_doc_count, o_doc_id, o_doc_frequency,
                    o_error_code, o_last));
                o_results_seen++;
            end
            if (push && !full)
                decode_byte(i_first_byte, i_data_byte, i_entry_length,
                            i_expected_ident);
            if (i_cfg_valid && o_cfg_ready) order_big = i_cfg_byte_order;
        end
        o_pending = expected_results.size();
    end

endmodule

@@ verif/tb_posting_record_decoder.sv @@
module tb_posting_record_decoder;
    import prd_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        i_first_byte = 1'b0;
    logic [7:0]  i_data_byte = '0;
    logic [31:0] i_entry_length = '0;
    logic [31:0] i_expected_ident = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  o_result_kind;
    logic [31:0] o_category;
    logic [31:0] o_term_frequency;
    logic [31:0] o_doc_count;
    logic [31:0] o_doc_id;
    logic [31:0] o_doc_frequency;
    logic [2:0]  o_error_code;
    logic        o_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_byte_order = 1'b0;

    int errors;
    int pending;
    int results_seen;
    int records_done;
    int bytes_sent;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    int cycle_count;
    logic big_endian;

    // Byte image of the record being built.
    logic [7:0] record_bytes[$];

    posting_record_decoder dut (.*);

    posting_record_checker checker_inst (
        .i_clk, .i_rst_n, .push, .full, .i_first_byte, .i_data_byte,
        .i_entry_length, .i_expected_ident, .empty, .pop, .o_result_kind,
        .o_category, .o_term_frequency, .o_doc_count, .o_doc_id,
        .o_doc_frequency, .o_error_code, .o_last, .i_cfg_valid, .o_cfg_ready,
        .i_cfg_byte_order,
        .o_errors(errors), .o_pending(pending), .o_results_seen(results_seen),
        .o_records_done(records_done)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offer one item and hold it until the block accepts it. The item stays
    // offered until the next call or an explicit release of push.
    task automatic send_byte(logic first, logic [7:0] b, logic [31:0] len,
                             logic [31:0] ident);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_first_byte <= first;
        i_data_byte <= b;
        i_entry_length <= len;
        i_expected_ident <= ident;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic append_byte(logic [7:0] b);
        record_bytes.insert(record_bytes.size(), b);
    endtask

    task automatic add_word(logic [31:0] w);
        for (int i = 0; i < 4; i++)
            append_byte(big_endian ? w[31 - 8 * i -: 8] : w[8 * i +: 8]);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            2: return $urandom_range(5);
            default: return $urandom;
        endcase
    endfunction

    // Build a well-formed record with random groups and send it; mode may
    // damage it: 1 flips a byte, 2 cuts it short, 3 passes a wrong length.
    task automatic send_record(int groups, int mode);
        logic [31:0] ident;
        logic [31:0] len;
        int ndocs;
        int cut;
        ident = pick_word();
        record_bytes.delete();
        append_byte(DefFlag);
        add_word(ident);
        add_word('0);
        for (int g = 0; g < groups; g++) begin
            ndocs = $urandom_range(3);
            append_byte(GroupFlag);
            add_word(pick_word());
            add_word(pick_word());
            add_word(32'(ndocs));
            for (int d = 0; d < ndocs; d++) begin
                add_word(pick_word());
                add_word(pick_word());
            end
        end
        len = 32'(record_bytes.size());
        for (int i = 0; i < 4; i++)
            record_bytes[5 + i] = big_endian ? 8'(32'(len - 9) >> (24 - 8 * i))
                                             : 8'(32'(len - 9) >> (8 * i));
        if (mode == 1)
            record_bytes[$urandom_range(len - 1)] ^= 8'(1 << $urandom_range(7));
        if (mode == 3)
            len = (len ^ (32'd1 << $urandom_range(31)));
        cut = (mode == 2) ? $urandom_range(record_bytes.size() - 1) + 1
                          : record_bytes.size();
        for (int i = 0; i < cut; i++)
            send_byte(i == 0, record_bytes[i], len, ident);
        // Sometimes one trailing byte, which the block ignores once the record is closed.
        if ($urandom_range(3) == 0)
            send_byte(1'b0, 8'($urandom), $urandom, $urandom);
    endtask

    // Change the byte order with the block idle.
    task automatic write_byte_order(logic value);
        push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        big_endian = value;
        i_cfg_valid <= 1'b1;
        i_cfg_byte_order <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        hold_cycles = 0;
        cycle_count = 0;
        bytes_sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        big_endian = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: truncated, flag and length errors, empty record, extreme field values.
        send_byte(1'b1, 8'hFF, 32'd0, 32'hFFFFFFFF);
        send_byte(1'b1, 8'h00, 32'd5, 32'd0);
        send_byte(1'b0, 8'h55, '1, '1);
        send_byte(1'b1, DefFlag, 32'd1, 32'd0);
        send_byte(1'b1, DefFlag, 32'hFFFFFFFF, 32'hFFFFFFFF);
        repeat (4) send_byte(1'b0, 8'hFF, 32'd0, 32'd0);
        repeat (4) send_byte(1'b0, 8'hFF, 32'd0, 32'd0);
        send_record(0, 0);
        send_record(1, 0);
        send_record(2, 3);

        write_byte_order(1'b1);
        send_record(2, 0);
        // Byte order flipped inside a record, which is then abandoned.
        send_byte(1'b1, DefFlag, 32'd9, 32'h01020304);
        send_byte(1'b0, 8'h04, 32'd0, 32'd0);
        send_byte(1'b0, 8'h03, 32'd0, 32'd0);
        push <= 1'b0;
        i_cfg_valid <= 1'b1;
        i_cfg_byte_order <= 1'b0;
        big_endian = 1'b0;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        send_byte(1'b0, 8'h02, 32'd0, 32'd0);
        send_record(1, 0);

        // Random phases with different idle patterns and byte orders.
        for (int ph = 0; ph < 8; ph++) begin
            write_byte_order(ph[0]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            if (ph == 4) hold_cycles = 300;
            while (bytes_sent < 150 * (ph + 1) + 20) begin
                case ($urandom_range(9))
                    0: send_record($urandom_range(3), 1);
                    1: send_record($urandom_range(3), 2);
                    2: send_record($urandom_range(2), 3);
                    default: send_record($urandom_range(3), 0);
                endcase
            end
        end

        push <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        $display("Sent %0d bytes in both byte orders; checked %0d results closing %0d records.",
                 bytes_sent, results_seen, records_done);
        if (errors == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
